### hdl/pta_pkg.sv
// Package for the page table allocator: sizes, command and status codes,
// and the request and entry types that pass between the controller and its memories.
// No dependencies.
package pta_pkg;

    localparam int PAGE_COUNT    = 64;
    localparam int PROCESS_COUNT = 64;
    localparam int VPAGES        = 64;

    localparam int CMD_W      = 2;
    localparam int PROC_W     = 6;
    localparam int PAGE_W     = 6;
    localparam int VPAGE_W    = 6;
    localparam int CNT_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int MAP_W      = 64;
    localparam int STORE_AW   = PAGE_W + VPAGE_W;
    localparam int STORE_DEPTH = PAGE_COUNT * VPAGES;

    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_MAP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_DATA  = 2'd2;

    // One directory entry: table page and number of mapped virtual pages.
    typedef struct packed {
        logic [PAGE_W-1:0] table_page;
        logic [CNT_W-1:0]  fill;
    } dir_entry_t;

    typedef struct packed {
        logic              we;
        logic [PROC_W-1:0] waddr;
        dir_entry_t        wdata;
        logic [PROC_W-1:0] raddr;
    } dir_req_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [PAGE_W-1:0]   wdata;
        logic [STORE_AW-1:0] raddr;
    } store_req_t;

endpackage

### hdl/pta_if.sv
// Command and response channels of the page table allocator.
// Depends on pta_pkg for field widths.
interface pta_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [pta_pkg::CMD_W-1:0]    command;
    logic [pta_pkg::PROC_W-1:0]   process;
    logic [pta_pkg::CNT_W-1:0]    pages_wanted;
    logic [pta_pkg::VPAGE_W-1:0]  virtual_page;

    modport source (output valid, command, process, pages_wanted, virtual_page, input ready);
    modport sink   (input valid, command, process, pages_wanted, virtual_page, output ready);
endinterface

interface pta_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pta_pkg::STATUS_W-1:0]  status;
    logic [pta_pkg::PAGE_W-1:0]    table_page;
    logic [pta_pkg::CNT_W-1:0]     pages_granted;
    logic                          mapped;
    logic [pta_pkg::PAGE_W-1:0]    physical_page;
    logic [pta_pkg::MAP_W-1:0]     free_map;

    modport source (output valid, status, table_page, pages_granted, mapped, physical_page,
                    free_map, input ready);
    modport sink   (input valid, status, table_page, pages_granted, mapped, physical_page,
                    free_map, output ready);
endinterface

### hdl/pta_dir.sv
// Per-process directory memory: table page and fill count, registered read.
// Depends on pta_pkg.
module pta_dir (
    input  logic              clk,
    input  logic              rst_n,
    input  pta_pkg::dir_req_t req,
    output pta_pkg::dir_entry_t rdata
);
    import pta_pkg::*;

    dir_entry_t                 mem [PROCESS_COUNT];
    logic [PROCESS_COUNT-1:0]   valid_reg;
    dir_entry_t                 rd_data_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
                valid_reg[req.waddr] <= 1'b1;
            rd_valid_reg <= valid_reg[req.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
        rd_data_reg <= mem[req.raddr];
    end

    // An entry never written reads as no table.
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

### hdl/pta_store.sv
// Page table store: one entry per table page and virtual page, registered read.
// Depends on pta_pkg.
module pta_store (
    input  logic                         clk,
    input  pta_pkg::store_req_t          req,
    output logic [pta_pkg::PAGE_W-1:0]   rdata
);
    import pta_pkg::*;

    logic [PAGE_W-1:0] mem [STORE_DEPTH];
    logic [PAGE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
        rd_data_reg <= mem[req.raddr];
    end

    assign rdata = rd_data_reg;

endmodule

### hdl/pta_ctrl.sv
// Command sequencer: page allocation, directory and store access, result register.
// Depends on pta_pkg and the channel interfaces.
module pta_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    pta_cmd_if.sink                     request,
    pta_rsp_if.source                   response,
    output pta_pkg::dir_req_t           dir_req,
    input  pta_pkg::dir_entry_t         dir_rdata,
    output pta_pkg::store_req_t         store_req,
    input  logic [pta_pkg::PAGE_W-1:0]  store_rdata
);
    import pta_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_ALLOC      = 3'd1;
    localparam logic [2:0] S_DIR_WAIT   = 3'd2;
    localparam logic [2:0] S_STORE_WAIT = 3'd3;
    localparam logic [2:0] S_FINISH     = 3'd4;

    localparam logic [CNT_W-1:0] PAGE_LIMIT  = CNT_W'(PAGE_COUNT);
    localparam logic [CNT_W-1:0] VPAGE_LIMIT = CNT_W'(VPAGES);

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    next_free_reg, next_free_next;
    logic                out_valid_reg, out_valid_next;

    logic [PROC_W-1:0]   process_reg, process_next;
    logic [VPAGE_W-1:0]  vpage_reg, vpage_next;
    logic [PAGE_W-1:0]   tp_reg, tp_next;
    logic [CNT_W-1:0]    target_reg, target_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PAGE_W-1:0]   res_table_reg, res_table_next;
    logic [CNT_W-1:0]    res_granted_reg, res_granted_next;
    logic                res_mapped_reg, res_mapped_next;
    logic [PAGE_W-1:0]   res_phys_reg, res_phys_next;
    logic [MAP_W-1:0]    res_map_reg, res_map_next;

    logic [STATUS_W-1:0] out_status_reg;
    logic [PAGE_W-1:0]   out_table_reg;
    logic [CNT_W-1:0]    out_granted_reg;
    logic                out_mapped_reg;
    logic [PAGE_W-1:0]   out_phys_reg;
    logic [MAP_W-1:0]    out_map_reg;

    logic                accept;
    logic                out_load;
    logic                pool_empty;
    logic [MAP_W-1:0]    map_now;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign pool_empty    = (next_free_reg == PAGE_LIMIT);

    // Pages are only ever taken lowest first and never returned, so the
    // allocated set is always pages below next_free.
    always_comb
    begin
        for (int p = 0; p < MAP_W; p++)
            map_now[p] = (p < PAGE_COUNT) && (CNT_W'(p) < next_free_reg);
    end

    always_comb
    begin
        state_next       = state_reg;
        next_free_next   = next_free_reg;
        process_next     = process_reg;
        vpage_next       = vpage_reg;
        tp_next          = tp_reg;
        target_next      = target_reg;
        idx_next         = idx_reg;
        res_status_next  = res_status_reg;
        res_table_next   = res_table_reg;
        res_granted_next = res_granted_reg;
        res_mapped_next  = res_mapped_reg;
        res_phys_next    = res_phys_reg;
        res_map_next     = res_map_reg;
        out_load         = 1'b0;
        out_valid_next   = out_valid_reg && !response.ready;

        dir_req       = '0;
        dir_req.raddr = request.process;
        store_req       = '0;
        store_req.raddr = {dir_rdata.table_page, vpage_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    process_next     = request.process;
                    vpage_next       = request.virtual_page;
                    res_status_next  = ST_OK;
                    res_table_next   = '0;
                    res_granted_next = '0;
                    res_mapped_next  = 1'b0;
                    res_phys_next    = '0;
                    res_map_next     = '0;
                    case (request.command)
                        CMD_ALLOC:
                        begin
                            if (int'(request.process) >= PROCESS_COUNT || pool_empty)
                            begin
                                res_status_next = ST_NO_TABLE;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                tp_next        = next_free_reg[PAGE_W-1:0];
                                res_table_next = next_free_reg[PAGE_W-1:0];
                                next_free_next = next_free_reg + 1'b1;
                                target_next    = (request.pages_wanted > VPAGE_LIMIT) ?
                                                 VPAGE_LIMIT : request.pages_wanted;
                                idx_next       = '0;
                                state_next     = S_ALLOC;
                            end
                        end
                        CMD_LOOKUP:
                            state_next = S_DIR_WAIT;
                        CMD_READ_MAP:
                        begin
                            res_map_next = map_now;
                            state_next   = S_FINISH;
                        end
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (idx_reg == target_reg || pool_empty)
                begin
                    if (idx_reg != target_reg)
                        res_status_next = ST_NO_DATA;
                    res_granted_next          = idx_reg;
                    dir_req.we                = 1'b1;
                    dir_req.waddr             = process_reg;
                    dir_req.wdata.table_page  = tp_reg;
                    dir_req.wdata.fill        = idx_reg;
                    state_next                = S_FINISH;
                end
                else
                begin
                    // Map virtual page idx to the lowest free page.
                    store_req.we    = 1'b1;
                    store_req.waddr = {tp_reg, idx_reg[VPAGE_W-1:0]};
                    store_req.wdata = next_free_reg[PAGE_W-1:0];
                    next_free_next  = next_free_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                end
            end

            S_DIR_WAIT:
            begin
                // Entries at or beyond the fill count were never written: unmapped.
                if (int'(process_reg) < PROCESS_COUNT && dir_rdata.table_page != '0 &&
                    {1'b0, vpage_reg} < dir_rdata.fill)
                    state_next = S_STORE_WAIT;
                else
                    state_next = S_FINISH;
            end

            S_STORE_WAIT:
            begin
                res_phys_next   = store_rdata;
                res_mapped_next = (store_rdata != '0);
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        process_reg     <= process_next;
        vpage_reg       <= vpage_next;
        tp_reg          <= tp_next;
        target_reg      <= target_next;
        idx_reg         <= idx_next;
        res_status_reg  <= res_status_next;
        res_table_reg   <= res_table_next;
        res_granted_reg <= res_granted_next;
        res_mapped_reg  <= res_mapped_next;
        res_phys_reg    <= res_phys_next;
        res_map_reg     <= res_map_next;
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_table_reg   <= res_table_reg;
            out_granted_reg <= res_granted_reg;
            out_mapped_reg  <= res_mapped_reg;
            out_phys_reg    <= res_phys_reg;
            out_map_reg     <= res_map_reg;
        end
    end

    assign response.valid         = out_valid_reg;
    assign response.status        = out_status_reg;
    assign response.table_page    = out_table_reg;
    assign response.pages_granted = out_granted_reg;
    assign response.mapped        = out_mapped_reg;
    assign response.physical_page = out_phys_reg;
    assign response.free_map      = out_map_reg;

endmodule

### hdl/page_table_allocator.sv
// Single-level page table allocator. Physical page 0 is reserved; pages are
// handed out lowest first and never returned. A new-process command takes one
// page as the process's page table and then one page per requested data page
// (capped at 64), writing one page-table entry per cycle into the page table
// store. The store has a single write port, so its entries are written one
// at a time. A lookup reads the directory, then the store, then presents
// its result; it skips the store read when the process has no table or the
// virtual page lies beyond its fill count. A free-map read or an unused
// command goes straight to the result. One command is worked on at a time;
// the result sits in an output register, so the next command is taken while
// an earlier result still waits for its transfer, and a finished result is
// held until that register is free. The directory keeps a fill count per
// process, so the store needs no clearing after reset and the block is ready
// to take commands at once.
// Depends on pta_pkg, the channel interfaces, pta_dir, pta_store and pta_ctrl.
module page_table_allocator (
    input  logic      clk,
    input  logic      rst_n,
    pta_cmd_if.sink   request,
    pta_rsp_if.source response
);
    import pta_pkg::*;

    dir_req_t            dir_req;
    dir_entry_t          dir_rdata;
    store_req_t          store_req;
    logic [PAGE_W-1:0]   store_rdata;

    // Sequencer: owns the allocation pointer and the result register.
    pta_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .response    (response),
        .dir_req     (dir_req),
        .dir_rdata   (dir_rdata),
        .store_req   (store_req),
        .store_rdata (store_rdata)
    );

    // Per-process table page and fill count.
    pta_dir u_dir (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dir_req),
        .rdata (dir_rdata)
    );

    // Page table entries, addressed by table page and virtual page.
    pta_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

endmodule

### hdl/pta_checker.sv
// Port-level checks for page_table_allocator, attached with a bind.
// Depends on pta_pkg.
module pta_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [pta_pkg::STATUS_W-1:0]  rsp_status,
    input logic [pta_pkg::PAGE_W-1:0]    rsp_table_page,
    input logic [pta_pkg::CNT_W-1:0]     rsp_pages_granted,
    input logic                          rsp_mapped,
    input logic [pta_pkg::PAGE_W-1:0]    rsp_physical_page,
    input logic [pta_pkg::MAP_W-1:0]     rsp_free_map
);
    import pta_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_physical_page) && $stable(rsp_free_map))
        else $error("response dropped or changed while stalled");

    a_mapped_phys: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_mapped == (rsp_physical_page != '0)))
        else $error("mapped flag disagrees with physical page");

    a_no_table: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_NO_TABLE |->
        rsp_table_page == '0 && rsp_pages_granted == '0 && rsp_free_map == '0)
        else $error("table shortage reported with allocation data");

    a_page0_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_free_map != '0 |-> rsp_free_map[0])
        else $error("free map shows page 0 as free");

endmodule

bind page_table_allocator pta_checker u_pta_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (response.valid),
    .rsp_ready         (response.ready),
    .rsp_status        (response.status),
    .rsp_table_page    (response.table_page),
    .rsp_pages_granted (response.pages_granted),
    .rsp_mapped        (response.mapped),
    .rsp_physical_page (response.physical_page),
    .rsp_free_map      (response.free_map)
);
